// ===== hw/rtl/shd_pkg.sv =====
// Shared types, register indexes and reset values for the strip detector hit selector.
// No dependencies; used by shd_bank and strip_detector_hit_selector.
`default_nettype none

package shd_pkg;

    localparam int STRIP_COUNT_DEFAULT = 32;
    localparam int STRIP_W             = 5;
    localparam int ENERGY_W            = 16;
    localparam int SUM_W               = ENERGY_W + 1;
    localparam int CFG_INDEX_W         = 1;
    localparam int CFG_DATA_W          = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FB_DIFF      = 1'd1;

    localparam logic [ENERGY_W-1:0] ENERGY_THRESHOLD_RESET = 16'd3000;
    localparam logic [ENERGY_W-1:0] MAX_FB_DIFF_RESET      = 16'd3000;

    typedef logic [STRIP_W-1:0]  t_strip;
    typedef logic [ENERGY_W-1:0] t_energy;
    typedef logic [SUM_W-1:0]    t_sum;

    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_LEFT  = 2'd1,
        HIT_RIGHT = 2'd2
    } t_hit_side;

    // Input word: one strip of an event
    typedef struct packed {
        t_strip  strip_index;
        t_energy energy_left_front;
        t_energy energy_left_back;
        t_energy energy_right_front;
        t_energy energy_right_back;
        logic    last_strip;
    } t_strip_word;

    // Output word: decision for one event
    typedef struct packed {
        t_hit_side hit_side;
        t_strip    front_strip;
        t_strip    back_strip;
        t_sum      energy_sum;
    } t_hit_word;

    // Running maximum of one bank as seen after the current strip is folded in
    typedef struct packed {
        logic    passed;
        t_energy max_energy;
        t_strip  max_strip;
    } t_bank_view;

endpackage

`default_nettype wire

// ===== hw/rtl/shd_bank.sv =====
// Running maximum tracker for one energy bank (energy, strip index, passed flag).
// Depends on shd_pkg.
`default_nettype none

module shd_bank (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  shd_pkg::t_energy     i_threshold,
    input  wire                  i_update,
    input  wire                  i_rearm,
    input  shd_pkg::t_energy     i_energy,
    input  shd_pkg::t_strip      i_strip,
    output shd_pkg::t_bank_view  o_view
);
    import shd_pkg::*;

    logic    r_passed;
    t_energy r_max_energy;
    t_strip  r_max_strip;

    t_energy cur_max;
    logic    take;

    // Banks that have not passed compare against the live threshold
    assign cur_max = r_passed ? r_max_energy : i_threshold;
    assign take    = i_update && (i_energy > cur_max);

    // Present the maximum with this strip folded in
    always_comb begin
        o_view.passed     = r_passed || take;
        o_view.max_energy = take ? i_energy : cur_max;
        o_view.max_strip  = take ? i_strip : r_max_strip;
    end

    // Hold the running maximum; rearm after the last strip of an event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passed    <= 1'b0;
            r_max_strip <= '0;
        end else if (i_rearm) begin
            r_passed    <= 1'b0;
            r_max_strip <= '0;
        end else if (take) begin
            r_passed    <= 1'b1;
            r_max_strip <= i_strip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_max_energy <= i_energy;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/strip_detector_hit_selector.sv =====
// Top level of the strip detector hit selector: input register, four bank trackers,
// side decision and result register. Depends on shd_pkg and shd_bank.
//
// The block takes one strip word per clock while o_in_stall is low and keeps, for
// each of the four banks (left front, left back, right front, right back), the
// largest energy strictly above energy_threshold and the strip where it first
// occurred. The word flagged last_strip closes the event: its strip is folded in,
// the hit side is decided and one hit word is produced, and the banks rearm for the
// next event. A word is accepted whenever o_in_stall is low; it passes the input
// register r_s1 and the bank update and decision logic, and its result is loaded
// into the output register r_out, where it is held until taken. Only a stalled hit
// word that is still held when the next last_strip word reaches the decision stage
// holds off input. Strip words with an index at or above STRIP_COUNT leave the banks
// alone but still close the event when flagged last.
`default_nettype none

module strip_detector_hit_selector #(
    parameter int STRIP_COUNT = shd_pkg::STRIP_COUNT_DEFAULT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write port
    input  wire                                 i_cfg_we,
    input  wire [shd_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire [shd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // strip words
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  shd_pkg::t_strip_word                i_in_data,
    // hit words
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output shd_pkg::t_hit_word                  o_out_data
);
    import shd_pkg::*;

    localparam int BANKS = 4;
    localparam int LF = 0;
    localparam int LB = 1;
    localparam int RF = 2;
    localparam int RB = 3;

    t_energy     r_threshold;
    t_energy     r_max_fb_diff;

    logic        r_s1_valid;
    t_strip_word r_s1;

    logic        r_out_valid;
    t_hit_word   r_out;

    logic        out_free;
    logic        fire;
    logic        strip_ok;
    t_energy     bank_energy [BANKS];
    t_bank_view  view [BANKS];
    logic        left_wins;
    logic        right_wins;
    t_hit_word   n_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= ENERGY_THRESHOLD_RESET;
            r_max_fb_diff <= MAX_FB_DIFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENERGY_THRESHOLD: r_threshold   <= i_cfg_data;
                REG_MAX_FB_DIFF:      r_max_fb_diff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the decision stage unless a closing word meets a held hit word
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && (!r_s1.last_strip || out_free);
    assign o_in_stall = r_s1_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1 <= i_in_data;
        end
    end

    // Drop energies of strips outside the detector
    assign strip_ok = (32'(r_s1.strip_index) < STRIP_COUNT);

    assign bank_energy[LF] = r_s1.energy_left_front;
    assign bank_energy[LB] = r_s1.energy_left_back;
    assign bank_energy[RF] = r_s1.energy_right_front;
    assign bank_energy[RB] = r_s1.energy_right_back;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        shd_bank u_bank (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_threshold (r_threshold),
            .i_update    (fire && strip_ok),
            .i_rearm     (fire && r_s1.last_strip),
            .i_energy    (bank_energy[b]),
            .i_strip     (r_s1.strip_index),
            .o_view      (view[b])
        );
    end

    function automatic logic side_wins(t_bank_view f, t_bank_view k,
                                       t_bank_view of, t_bank_view ok,
                                       t_energy lim);
        t_energy diff;
        diff = (f.max_energy > k.max_energy) ? (f.max_energy - k.max_energy)
                                             : (k.max_energy - f.max_energy);
        return f.passed && k.passed && (diff < lim) &&
               (f.max_energy > of.max_energy) && (k.max_energy > ok.max_energy);
    endfunction

    // Decide the hit side from the maxima after the closing strip
    assign left_wins  = side_wins(view[LF], view[LB], view[RF], view[RB], r_max_fb_diff);
    assign right_wins = side_wins(view[RF], view[RB], view[LF], view[LB], r_max_fb_diff);

    always_comb begin
        n_out = '0;
        n_out.hit_side = HIT_NONE;
        if (left_wins) begin
            n_out.hit_side    = HIT_LEFT;
            n_out.front_strip = view[LF].max_strip;
            n_out.back_strip  = view[LB].max_strip;
            n_out.energy_sum  = SUM_W'(view[LF].max_energy) + SUM_W'(view[LB].max_energy);
        end else if (right_wins) begin
            n_out.hit_side    = HIT_RIGHT;
            n_out.front_strip = view[RF].max_strip;
            n_out.back_strip  = view[RB].max_strip;
            n_out.energy_sum  = SUM_W'(view[RF].max_energy) + SUM_W'(view[RB].max_energy);
        end
    end

    // Load the hit word on a closing strip; release it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_s1.last_strip) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_s1.last_strip) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
